// File: rtl/core/b64e_pkg.sv
package b64e_pkg;

  localparam logic [7:0] PadChar = 8'h3D;  // '='

  // Number of real bytes in a group (one, two or three)
  localparam logic [1:0] HaveOne   = 2'd1;
  localparam logic [1:0] HaveTwo   = 2'd2;
  localparam logic [1:0] HaveThree = 2'd3;

  // Character slot within a group of four
  localparam logic [1:0] SlotFirst  = 2'd0;
  localparam logic [1:0] SlotSecond = 2'd1;
  localparam logic [1:0] SlotThird  = 2'd2;
  localparam logic [1:0] SlotFourth = 2'd3;

  typedef struct packed {
    logic [23:0] bits;  // first byte in 23:16, zero-filled
    logic [1:0]  have;  // real bytes in the group
    logic        fin;   // group closes the stream
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Standard alphabet lookup
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    c = 8'h2F;  // '/'
    case (v) inside
      [6'd0 : 6'd25]:  c = 8'h41 + {2'b00, v};
      [6'd26 : 6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
      [6'd52 : 6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
      6'd62:           c = 8'h2B;  // '+'
      default:         c = 8'h2F;  // '/'
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/b64e_front.sv
module b64e_front
  import b64e_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    data_byte_i,
  input  logic          final_byte_i,
  input  queue_status_t status_i,
  output logic          push_o,
  output group_t        group_o
);

  logic [15:0] pending_bytes_q, pending_bytes_d;
  logic [1:0]  pending_count_q, pending_count_d;
  logic [1:0]  cnt;
  logic        accept;
  logic        store;

  assign in_stall_o = status_i.full;
  assign accept     = in_valid_i && !status_i.full;
  // a count of three cannot arise; treat it as two
  assign cnt        = (pending_count_q == 2'd3) ? 2'd2 : pending_count_q;
  assign store      = !final_byte_i && (cnt < 2'd2);

  always_comb begin
    group_o.fin = final_byte_i;
    case (cnt)
      2'd0: begin
        group_o.bits = {data_byte_i, 16'h0000};
        group_o.have = HaveOne;
      end
      2'd1: begin
        group_o.bits = {pending_bytes_q[15:8], data_byte_i, 8'h00};
        group_o.have = HaveTwo;
      end
      default: begin
        group_o.bits = {pending_bytes_q, data_byte_i};
        group_o.have = HaveThree;
      end
    endcase
  end

  always_comb begin
    pending_bytes_d = pending_bytes_q;
    pending_count_d = pending_count_q;
    push_o          = 1'b0;
    if (accept) begin
      if (store) begin
        pending_bytes_d = (cnt == 2'd0) ? {data_byte_i, 8'h00}
                                        : {pending_bytes_q[15:8], data_byte_i};
        pending_count_d = cnt + 2'd1;
      end else begin
        pending_bytes_d = 16'h0000;
        pending_count_d = 2'd0;
        push_o          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_bytes_q <= 16'h0000;
      pending_count_q <= 2'd0;
    end else begin
      pending_bytes_q <= pending_bytes_d;
      pending_count_q <= pending_count_d;
    end
  end

endmodule

// File: rtl/core/b64e_queue.sv
module b64e_queue
  import b64e_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  group_t        push_data_i,
  input  logic          pop_i,
  output group_t        head_o,
  output queue_status_t status_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  group_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/b64e_back.sv
module b64e_back
  import b64e_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  group_t        head_i,
  input  queue_status_t status_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_char_o,
  output logic          group_end_o,
  output logic          stream_end_o
);

  logic [1:0] slot_q;
  logic       out_valid_q;
  logic [7:0] out_char_q, char_d;
  logic       group_end_q, stream_end_q;
  logic       advance, emit;

  assign advance = !out_valid_q || !out_stall_i;
  assign emit    = advance && !status_i.empty;
  assign pop_o   = emit && (slot_q == SlotFourth);

  always_comb begin
    case (slot_q)
      SlotFirst:  char_d = sextet_char(head_i.bits[23:18]);
      SlotSecond: char_d = sextet_char(head_i.bits[17:12]);
      SlotThird:  char_d = (head_i.have == HaveOne) ? PadChar
                                                    : sextet_char(head_i.bits[11:6]);
      default:    char_d = (head_i.have == HaveThree) ? sextet_char(head_i.bits[5:0])
                                                      : PadChar;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= SlotFirst;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
      if (emit) begin
        slot_q <= slot_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q   <= char_d;
      group_end_q  <= (slot_q == SlotFourth);
      stream_end_q <= (slot_q == SlotFourth) && head_i.fin;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign group_end_o  = group_end_q;
  assign stream_end_o = stream_end_q;

endmodule

// File: rtl/core/base64_stream_encoder_core.sv
// Base64 stream encoder: one raw byte in per word, one ASCII character out per word.
// Each group is registered in the queue once the byte that completes (or finally closes)
//   it is taken, and each of its characters is then registered in the output word.
// Throughput: one byte per cycle in until the queue fills, one character per cycle out
//   while out_stall_i is low; short final groups also give four characters, padded.
// Reset (rst_ni, async, active low) empties the pending bytes and the group queue.
module base64_stream_encoder_core
  import b64e_pkg::*;
#(
  parameter int QueueDepth = 2  // groups held between front and back, >= 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // byte input
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  // character output
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       group_end_o,
  output logic       stream_end_o
);

  // Front: collects bytes into groups of three, or closes a short group on
  // the final byte. Only completed groups enter the queue, so a byte that is
  // merely stored never waits on the back end except when the queue is full.
  group_t        push_group;
  logic          push;
  group_t        head_group;
  logic          pop;
  queue_status_t q_status;

  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .status_i     (q_status),
    .push_o       (push),
    .group_o      (push_group)
  );

  // Queue of finished groups; decouples byte intake from character output.
  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_group),
    .pop_i       (pop),
    .head_o      (head_group),
    .status_o    (q_status)
  );

  // Back: walks the head group through its four sextets into a registered
  // output word, padding with '=' where the group is short; pops on the fourth.
  b64e_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_group),
    .status_i     (q_status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .group_end_o  (group_end_o),
    .stream_end_o (stream_end_o)
  );

  // A pushed group never gets dropped at the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("group pushed into a full queue");

  // The back end only retires a group that is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("pop from an empty queue");

  // End of stream always lands on the last character of a group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stream_end_o) |-> group_end_o)
    else $error("stream end off a group boundary");

endmodule
